// ===== hdl/fcpr_pkg.sv =====
// ---------------------------------------------------------------------------
// fcpr_pkg
// Shared constants, beat types and the arctangent table of the Fresnel chirp
// phase rotator.
// ---------------------------------------------------------------------------
package fcpr_pkg;

   // frame geometry (log2 of width and height)
   localparam int LOG_WIDTH  = 11;
   localparam int LOG_HEIGHT = 11;

   // port field widths
   localparam int SAMPLE_W = 32;
   localparam int COL_W    = 11;
   localparam int ROW_W    = 11;
   localparam int PHASE_W  = 32;

   // distance datapath widths
   localparam int CX_W     = (LOG_WIDTH > COL_W) ? LOG_WIDTH : COL_W;
   localparam int CY_W     = (LOG_HEIGHT > ROW_W) ? LOG_HEIGHT : ROW_W;
   localparam int DX_W     = LOG_WIDTH + 1;
   localparam int DY_W     = LOG_HEIGHT + 1;
   localparam int SQX_W    = 2 * LOG_WIDTH - 1;
   localparam int SQY_W    = 2 * LOG_HEIGHT - 1;
   localparam int D2_W     = ((SQX_W > SQY_W) ? SQX_W : SQY_W) + 1;
   localparam int X_CENTER = 1 << (LOG_WIDTH - 1);
   localparam int Y_CENTER = 1 << (LOG_HEIGHT - 1);

   // rotator widths
   localparam int CORDIC_STAGES = 30;
   localparam int GUARD_BITS    = 8;
   localparam int XY_W          = 43;
   localparam int Z_W           = 33;

   // gain compensation, Q32 split in two 16-bit halves
   localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
   localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;
   localparam int OUT_SHIFT = 32 + GUARD_BITS + LOG_WIDTH + LOG_HEIGHT;

   // quadrant codes of the coarse rotation
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // register map
   localparam int         CSR_ADDR_W     = 3;
   localparam int         CSR_DATA_W     = 32;
   localparam int         CSR_IDX_BIT    = 2;
   localparam logic       REG_PHASE_STEP = 1'b0;

   // atan(2^-i) in 2^-32 turn
   localparam logic [31:0] ATAN_TURNS [0:CORDIC_STAGES-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1
   };

   // sample and its chirp angle, out of the distance stages
   typedef struct packed {
      logic [SAMPLE_W-1:0] re;
      logic [SAMPLE_W-1:0] im;
      logic [PHASE_W-1:0]  theta;
   } phase_beat_type;

   // rotated vector with guard bits, out of the rotator
   typedef struct packed {
      logic [XY_W-1:0] x;
      logic [XY_W-1:0] y;
   } vec_beat_type;

endpackage

// ===== hdl/fresnel_chirp_phase_rotator_top.sv =====
// ---------------------------------------------------------------------------
// fresnel_chirp_phase_rotator_top
// Multiplies a stream of complex frequency samples by the Fresnel transfer
// chirp and normalizes them for the inverse transform.
// ---------------------------------------------------------------------------
// Takes one beat per clock unless stalled and returns one beat per input,
// in order, through three register stages for the squared center distance
// and the 22x32 phase multiply, one for the quarter-turn rotation, one per
// each of the 30 CORDIC iterations and two for gain compensation and
// rounding. The whole pipeline is one chain that advances together; a
// stalled result freezes every stage and holds req_stall high, so nothing
// is dropped or repeated. phase_step (2^-32 turn per squared pixel) sits at
// address 0 and should only be written while no beat is in flight.
module fresnel_chirp_phase_rotator_top (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [fcpr_pkg::SAMPLE_W-1:0] req_sample_re,
   input  logic signed [fcpr_pkg::SAMPLE_W-1:0] req_sample_im,
   input  logic [fcpr_pkg::COL_W-1:0]      req_col,
   input  logic [fcpr_pkg::ROW_W-1:0]      req_row,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [fcpr_pkg::SAMPLE_W-1:0] rsp_out_re,
   output logic signed [fcpr_pkg::SAMPLE_W-1:0] rsp_out_im,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fcpr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fcpr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fcpr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import fcpr_pkg::*;

   logic                 advance;
   logic                 csr_wr;
   logic [PHASE_W-1:0]   phase_step_ff;
   logic                 dist_valid;
   phase_beat_type       dist_beat;
   logic                 rot_valid;
   vec_beat_type         rot_beat;
   logic [SAMPLE_W-1:0]  out_re, out_im;

   // whole chain moves unless the result register is blocked
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
      end else if (csr_wr && (csr_paddr[CSR_IDX_BIT] == REG_PHASE_STEP)) begin
         phase_step_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[CSR_IDX_BIT] == REG_PHASE_STEP) ? phase_step_ff : '0;

   fcpr_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .sample_re  (req_sample_re),
      .sample_im  (req_sample_im),
      .col        (req_col),
      .row        (req_row),
      .phase_step (phase_step_ff),
      .out_valid  (dist_valid),
      .out_beat   (dist_beat)
   );

   fcpr_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dist_valid),
      .in_beat   (dist_beat),
      .out_valid (rot_valid),
      .out_beat  (rot_beat)
   );

   fcpr_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rot_valid),
      .in_beat   (rot_beat),
      .out_valid (rsp_valid),
      .out_re    (out_re),
      .out_im    (out_im)
   );

   assign rsp_out_re = $signed(out_re);
   assign rsp_out_im = $signed(out_im);

`ifndef SYNTHESIS
   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input is only held off by a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // a write to the phase step lands
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && (csr_paddr[CSR_IDX_BIT] == REG_PHASE_STEP))
      |=> (phase_step_ff == $past(csr_pwdata)))
      else $error("phase step write lost");

   // writes outside the map leave the register alone
   a_cfg_other: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && (csr_paddr[CSR_IDX_BIT] != REG_PHASE_STEP)) |=> $stable(phase_step_ff))
      else $error("phase step changed by unmapped write");
`endif

endmodule

// ===== hdl/fcpr_dist.sv =====
// ---------------------------------------------------------------------------
// fcpr_dist
// Squared distance from the frame center and chirp angle, three stages:
// squares, sum, multiply by the phase step modulo one turn.
// ---------------------------------------------------------------------------
module fcpr_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [fcpr_pkg::SAMPLE_W-1:0] sample_re,
   input  logic [fcpr_pkg::SAMPLE_W-1:0] sample_im,
   input  logic [fcpr_pkg::COL_W-1:0]    col,
   input  logic [fcpr_pkg::ROW_W-1:0]    row,
   input  logic [fcpr_pkg::PHASE_W-1:0]  phase_step,
   output logic                          out_valid,
   output fcpr_pkg::phase_beat_type      out_beat
);
   import fcpr_pkg::*;

   logic [CX_W-1:0]            col_ext;
   logic [CY_W-1:0]            row_ext;
   logic signed [DX_W-1:0]     dx;
   logic signed [DY_W-1:0]     dy;
   logic signed [2*DX_W-1:0]   dx_sq;
   logic signed [2*DY_W-1:0]   dy_sq;
   logic [D2_W+PHASE_W-1:0]    theta_prod;

   logic                       v1_ff, v2_ff, v3_ff;
   logic [SQX_W-1:0]           sqx_ff;
   logic [SQY_W-1:0]           sqy_ff;
   logic [D2_W-1:0]            d2_ff;
   logic [D2_W-1:0]            d2_in;
   logic [PHASE_W-1:0]         theta_ff;
   logic [PHASE_W-1:0]         theta_in;
   logic [SAMPLE_W-1:0]        re1_ff, im1_ff, re2_ff, im2_ff, re3_ff, im3_ff;

   // offsets from center; index wraps to the frame size
   assign col_ext = CX_W'(col);
   assign row_ext = CY_W'(row);
   assign dx      = $signed({1'b0, col_ext[LOG_WIDTH-1:0]} - DX_W'(X_CENTER));
   assign dy      = $signed({1'b0, row_ext[LOG_HEIGHT-1:0]} - DY_W'(Y_CENTER));
   assign dx_sq   = (2*DX_W)'(dx) * (2*DX_W)'(dx);
   assign dy_sq   = (2*DY_W)'(dy) * (2*DY_W)'(dy);

   // stage 1: squares
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff <= dx_sq[SQX_W-1:0];
         sqy_ff <= dy_sq[SQY_W-1:0];
         re1_ff <= sample_re;
         im1_ff <= sample_im;
      end
   end

   // stage 2: squared distance
   assign d2_in = D2_W'(sqx_ff) + D2_W'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d2_ff  <= d2_in;
         re2_ff <= re1_ff;
         im2_ff <= im1_ff;
      end
   end

   // stage 3: angle, low word of the product is modulo one turn
   assign theta_prod = (D2_W+PHASE_W)'(d2_ff) * (D2_W+PHASE_W)'(phase_step);
   assign theta_in   = theta_prod[PHASE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         theta_ff <= theta_in;
         re3_ff   <= re2_ff;
         im3_ff   <= im2_ff;
      end
   end

   assign out_valid      = v3_ff;
   assign out_beat.re    = re3_ff;
   assign out_beat.im    = im3_ff;
   assign out_beat.theta = theta_ff;

endmodule

// ===== hdl/fcpr_cordic.sv =====
// ---------------------------------------------------------------------------
// fcpr_cordic
// Rotation by the negative chirp angle: an exact quarter-turn stage and then
// one register stage per CORDIC iteration.
// ---------------------------------------------------------------------------
module fcpr_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  fcpr_pkg::phase_beat_type in_beat,
   output logic                     out_valid,
   output fcpr_pkg::vec_beat_type   out_beat
);
   import fcpr_pkg::*;

   logic [PHASE_W-1:0]      phi;
   logic [PHASE_W-1:0]      phi_bias;
   logic [1:0]              quad;
   logic [PHASE_W-1:0]      resid;
   logic signed [XY_W-1:0]  re_g, im_g;
   logic signed [XY_W-1:0]  x0_in, y0_in;
   logic signed [Z_W-1:0]   z0_in;

   logic                    v_ff [0:CORDIC_STAGES];
   logic signed [XY_W-1:0]  x_ff [0:CORDIC_STAGES];
   logic signed [XY_W-1:0]  y_ff [0:CORDIC_STAGES];
   logic signed [Z_W-1:0]   z_ff [0:CORDIC_STAGES-1];

   // coarse quadrant and signed residual angle
   assign phi      = PHASE_W'(0) - in_beat.theta;
   assign phi_bias = phi + 32'h2000_0000;
   assign quad     = phi_bias[PHASE_W-1:PHASE_W-2];
   assign resid    = phi - {quad, {(PHASE_W-2){1'b0}}};
   assign z0_in    = Z_W'($signed(resid));

   // sample with guard bits
   assign re_g = XY_W'($signed(in_beat.re)) <<< GUARD_BITS;
   assign im_g = XY_W'($signed(in_beat.im)) <<< GUARD_BITS;

   // exact quarter-turn rotation
   always_comb begin
      case (quad)
         QUAD_0: begin
            x0_in = re_g;
            y0_in = im_g;
         end
         QUAD_1: begin
            x0_in = -im_g;
            y0_in = re_g;
         end
         QUAD_2: begin
            x0_in = -re_g;
            y0_in = -im_g;
         end
         QUAD_3: begin
            x0_in = im_g;
            y0_in = -re_g;
         end
         default: begin
            x0_in = re_g;
            y0_in = im_g;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
      end
   end

   // micro-rotation stages
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [XY_W-1:0] xs, ys, x_in, y_in;
      logic                   z_neg;

      assign xs    = x_ff[i] >>> i;
      assign ys    = y_ff[i] >>> i;
      assign z_neg = z_ff[i][Z_W-1];
      assign x_in  = z_neg ? (x_ff[i] + ys) : (x_ff[i] - ys);
      assign y_in  = z_neg ? (y_ff[i] - xs) : (y_ff[i] + xs);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
         end
      end

      // last stage leaves no angle behind
      if (i < CORDIC_STAGES - 1) begin : g_angle
         logic signed [Z_W-1:0] z_in;

         assign z_in = z_neg ? (z_ff[i] + Z_W'(ATAN_TURNS[i]))
                             : (z_ff[i] - Z_W'(ATAN_TURNS[i]));

         always_ff @(posedge clock) begin
            if (advance) begin
               z_ff[i+1] <= z_in;
            end
         end
      end
   end

   assign out_valid  = v_ff[CORDIC_STAGES];
   assign out_beat.x = x_ff[CORDIC_STAGES];
   assign out_beat.y = y_ff[CORDIC_STAGES];

endmodule

// ===== hdl/fcpr_scale.sv =====
// ---------------------------------------------------------------------------
// fcpr_scale
// CORDIC gain compensation, rounding normalization and saturation: partial
// products in one stage, round/shift/clip into the result register.
// ---------------------------------------------------------------------------
module fcpr_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  fcpr_pkg::vec_beat_type        in_beat,
   output logic                          out_valid,
   output logic [fcpr_pkg::SAMPLE_W-1:0] out_re,
   output logic [fcpr_pkg::SAMPLE_W-1:0] out_im
);
   import fcpr_pkg::*;

   localparam int PROD_W = XY_W + 17;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic signed [16:0]      GAIN_HI_S = {1'b0, INV_GAIN_HI};
   localparam logic signed [16:0]      GAIN_LO_S = {1'b0, INV_GAIN_LO};
   localparam logic signed [SUM_W-1:0] HALF      = SUM_W'(1) <<< (OUT_SHIFT - 17);
   localparam logic signed [SUM_W-1:0] SAT_MAX   = SUM_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_MIN   = SUM_W'(33'sh1_8000_0000);

   // sum the halves, round half up, shift down and clip to 32 bits
   function automatic logic [SAMPLE_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] hi,
      input logic signed [PROD_W-1:0] lo
   );
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] shifted;
      logic [SAMPLE_W-1:0]     res;
      acc     = SUM_W'(hi) + HALF + SUM_W'(lo >>> 16);
      shifted = acc >>> (OUT_SHIFT - 16);
      if (shifted > SAT_MAX) begin
         res = SAT_MAX[SAMPLE_W-1:0];
      end else if (shifted < SAT_MIN) begin
         res = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         res = shifted[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   logic signed [XY_W-1:0]   x, y;
   logic signed [PROD_W-1:0] xhi_in, xlo_in, yhi_in, ylo_in;
   logic signed [PROD_W-1:0] xhi_ff, xlo_ff, yhi_ff, ylo_ff;
   logic                     vp_ff, vo_ff;
   logic [SAMPLE_W-1:0]      re_ff, im_ff;

   assign x = $signed(in_beat.x);
   assign y = $signed(in_beat.y);

   // stage 1: 16-bit partial products of the gain constant
   assign xhi_in = PROD_W'(x) * PROD_W'(GAIN_HI_S);
   assign xlo_in = PROD_W'(x) * PROD_W'(GAIN_LO_S);
   assign yhi_in = PROD_W'(y) * PROD_W'(GAIN_HI_S);
   assign ylo_in = PROD_W'(y) * PROD_W'(GAIN_LO_S);

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (advance) begin
         vp_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xhi_ff <= xhi_in;
         xlo_ff <= xlo_in;
         yhi_ff <= yhi_in;
         ylo_ff <= ylo_in;
      end
   end

   // stage 2: result register
   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (advance) begin
         vo_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         re_ff <= round_sat(xhi_ff, xlo_ff);
         im_ff <= round_sat(yhi_ff, ylo_ff);
      end
   end

   assign out_valid = vo_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;

endmodule
